// ===== rtl/swhr_pkg.sv =====
// Package with the shared constants, codes and types of the single-wire sensor reader.
`default_nettype none
package swhr_pkg;

   // Frame geometry
   localparam int FRAME_BITS  = 40;
   localparam int BIT_COUNT_W = $clog2(FRAME_BITS);
   localparam int BYTE_W      = 8;

   // Field widths
   localparam int MODE_W     = 2;
   localparam int LINE_W     = 4;
   localparam int INTERVAL_W = 16;
   localparam int PHASE_W    = 3;
   localparam int TICK_W     = 8;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_LOW_MS      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_LIMIT_US      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESPONSE_LIMIT_US = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_LIMIT_US      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_THRESHOLD_US  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_NUMBER       = 3'd5;

   // Register reset values
   localparam logic [TICK_W-1:0]     START_LOW_MS_RST      = 8'd19;
   localparam logic [INTERVAL_W-1:0] ACK_LIMIT_US_RST      = 16'd50;
   localparam logic [INTERVAL_W-1:0] RESPONSE_LIMIT_US_RST = 16'd200;
   localparam logic [INTERVAL_W-1:0] BIT_LIMIT_US_RST      = 16'd140;
   localparam logic [INTERVAL_W-1:0] ONE_THRESHOLD_US_RST  = 16'd100;
   localparam logic [LINE_W-1:0]     LINE_NUMBER_RST       = 4'd0;

   // Event codes
   localparam logic [MODE_W-1:0] MODE_START = 2'd0;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd2;

   // Phase codes
   localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_START = 3'd1;
   localparam logic [PHASE_W-1:0] PH_ACK   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_RESP  = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DATA  = 3'd4;
   localparam logic [PHASE_W-1:0] PH_READY = 3'd5;
   localparam logic [PHASE_W-1:0] PH_ERROR = 3'd6;

   localparam logic [TICK_W-1:0] TICK_MAX = '1;

   typedef struct packed {
      logic [TICK_W-1:0]     start_low_ms;
      logic [INTERVAL_W-1:0] ack_limit_us;
      logic [INTERVAL_W-1:0] response_limit_us;
      logic [INTERVAL_W-1:0] bit_limit_us;
      logic [INTERVAL_W-1:0] one_threshold_us;
      logic [LINE_W-1:0]     line_number;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]     mode;
      logic [LINE_W-1:0]     edge_line;
      logic [INTERVAL_W-1:0] edge_interval_us;
   } event_type;

endpackage
`default_nettype wire

// ===== rtl/swhr_req_if.sv =====
// Interface of the event channel into the sensor reader.
`default_nettype none
interface swhr_req_if;
   import swhr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [LINE_W-1:0]     edge_line;
   logic [INTERVAL_W-1:0] edge_interval_us;

   modport source (output valid, output mode, output edge_line, output edge_interval_us,
                   input ready);
   modport sink   (input valid, input mode, input edge_line, input edge_interval_us,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/swhr_rsp_if.sv =====
// Interface of the result channel out of the sensor reader.
`default_nettype none
interface swhr_rsp_if;
   import swhr_pkg::*;

   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] phase;
   logic               drive_low;
   logic               clear_interval_timer;
   logic               data_ready;
   logic [BYTE_W-1:0]  humidity_whole;
   logic [BYTE_W-1:0]  humidity_tenths;
   logic [BYTE_W-1:0]  temperature_whole;
   logic [BYTE_W-1:0]  temperature_tenths;

   modport source (output valid, output phase, output drive_low, output clear_interval_timer,
                   output data_ready, output humidity_whole, output humidity_tenths,
                   output temperature_whole, output temperature_tenths, input ready);
   modport sink   (input valid, input phase, input drive_low, input clear_interval_timer,
                   input data_ready, input humidity_whole, input humidity_tenths,
                   input temperature_whole, input temperature_tenths, output ready);
endinterface
`default_nettype wire

// ===== rtl/swhr_csr.sv =====
// Configuration registers of the sensor reader.
`default_nettype none
module swhr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [swhr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [swhr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output swhr_pkg::cfg_type                      cfg
);
   import swhr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_LOW_MS:      cfg_in.start_low_ms      = csr_wdata[TICK_W-1:0];
            CSR_ACK_LIMIT_US:      cfg_in.ack_limit_us      = csr_wdata[INTERVAL_W-1:0];
            CSR_RESPONSE_LIMIT_US: cfg_in.response_limit_us = csr_wdata[INTERVAL_W-1:0];
            CSR_BIT_LIMIT_US:      cfg_in.bit_limit_us      = csr_wdata[INTERVAL_W-1:0];
            CSR_ONE_THRESHOLD_US:  cfg_in.one_threshold_us  = csr_wdata[INTERVAL_W-1:0];
            CSR_LINE_NUMBER:       cfg_in.line_number       = csr_wdata[LINE_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low_ms      <= START_LOW_MS_RST;
         cfg_ff.ack_limit_us      <= ACK_LIMIT_US_RST;
         cfg_ff.response_limit_us <= RESPONSE_LIMIT_US_RST;
         cfg_ff.bit_limit_us      <= BIT_LIMIT_US_RST;
         cfg_ff.one_threshold_us  <= ONE_THRESHOLD_US_RST;
         cfg_ff.line_number       <= LINE_NUMBER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== rtl/swhr_core.sv =====
// Protocol state, frame shift register and result register of the sensor reader.
`default_nettype none
module swhr_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire swhr_pkg::cfg_type    cfg,
   input  wire logic                 evt_valid,
   input  wire swhr_pkg::event_type  evt,
   output logic                      evt_take,
   swhr_rsp_if.source                rsp
);
   import swhr_pkg::*;

   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [BIT_COUNT_W-1:0] bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic [4*BYTE_W-1:0]    reading_ff, reading_in;
   logic                   clear_timer;
   logic [TICK_W-1:0]      tick_inc;
   logic [FRAME_BITS-1:0]  frame_shift;
   logic [BYTE_W-1:0]      byte_sum;

   logic                   out_valid_ff;
   logic [PHASE_W-1:0]     out_phase_ff;
   logic                   out_clear_ff;
   logic [4*BYTE_W-1:0]    out_reading_ff;

   assign evt_take = evt_valid && (!out_valid_ff || rsp.ready);

   assign tick_inc    = (tick_ff != TICK_MAX) ? tick_ff + 1'b1 : tick_ff;
   assign frame_shift = {frame_ff[FRAME_BITS-2:0],
                         (evt.edge_interval_us > cfg.one_threshold_us)};
   // Bytes 0..3 sit at the top of the frame, the check byte at the bottom.
   assign byte_sum = frame_shift[FRAME_BITS-1 -: BYTE_W] + frame_shift[FRAME_BITS-9 -: BYTE_W]
                   + frame_shift[FRAME_BITS-17 -: BYTE_W] + frame_shift[FRAME_BITS-25 -: BYTE_W];

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_count_in = bit_count_ff;
      frame_in     = frame_ff;
      reading_in   = reading_ff;
      clear_timer  = 1'b0;
      case (evt.mode)
         MODE_START: begin
            phase_in = PH_START;
            tick_in  = '0;
         end
         MODE_TICK: begin
            if (phase_ff == PH_START) begin
               if (tick_inc >= cfg.start_low_ms) begin
                  phase_in    = PH_ACK;
                  tick_in     = '0;
                  clear_timer = 1'b1;
               end else begin
                  tick_in = tick_inc;
               end
            end
         end
         MODE_EDGE: begin
            if (evt.edge_line == cfg.line_number) begin
               clear_timer = 1'b1;
               case (phase_ff)
                  PH_ACK: begin
                     phase_in = (evt.edge_interval_us > cfg.ack_limit_us) ? PH_ERROR : PH_RESP;
                  end
                  PH_RESP: begin
                     if (evt.edge_interval_us > cfg.response_limit_us) begin
                        phase_in = PH_ERROR;
                     end else begin
                        phase_in     = PH_DATA;
                        frame_in     = '0;
                        bit_count_in = '0;
                     end
                  end
                  PH_DATA: begin
                     if (evt.edge_interval_us > cfg.bit_limit_us) begin
                        phase_in = PH_ERROR;
                     end else begin
                        frame_in     = frame_shift;
                        bit_count_in = bit_count_ff + 1'b1;
                        if (bit_count_ff >= BIT_COUNT_W'(FRAME_BITS - 1)) begin
                           if (byte_sum == frame_shift[BYTE_W-1:0]) begin
                              reading_in = frame_shift[FRAME_BITS-1:BYTE_W];
                              phase_in   = PH_READY;
                           end else begin
                              phase_in = PH_ERROR;
                           end
                        end
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         default: phase_in = phase_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         bit_count_ff <= '0;
         frame_ff     <= '0;
         reading_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (evt_take) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            bit_count_ff <= bit_count_in;
            frame_ff     <= frame_in;
            reading_ff   <= reading_in;
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (evt_take) begin
         out_phase_ff   <= phase_in;
         out_clear_ff   <= clear_timer;
         out_reading_ff <= reading_in;
      end
   end

   assign rsp.valid                = out_valid_ff;
   assign rsp.phase                = out_phase_ff;
   assign rsp.drive_low            = (out_phase_ff == PH_START);
   assign rsp.clear_interval_timer = out_clear_ff;
   assign rsp.data_ready           = (out_phase_ff == PH_READY);
   assign rsp.humidity_whole       = out_reading_ff[4*BYTE_W-1 -: BYTE_W];
   assign rsp.humidity_tenths      = out_reading_ff[3*BYTE_W-1 -: BYTE_W];
   assign rsp.temperature_whole    = out_reading_ff[2*BYTE_W-1 -: BYTE_W];
   assign rsp.temperature_tenths   = out_reading_ff[BYTE_W-1 -: BYTE_W];
endmodule
`default_nettype wire

// ===== rtl/single_wire_humidity_sensor_reader.sv =====
// Top level of the single-wire humidity and temperature sensor reader.
//
//   Channel   Direction  Handshake        Carries
//   req_ch    in         valid / ready    mode, edge_line, edge_interval_us
//   rsp_ch    out        valid / ready    phase, line control and last good reading
//   csr_*     in         csr_wr_en only   register index and write data
//
// Each event passes through the input register and then through the protocol update into the
// result register. A new event is accepted every cycle unless the result side stalls;
// the single protocol state register, updated once per event, sets that rate.
// Reset is synchronous and returns the phase to idle and the registers to their defaults.
// When the result side stalls, the result register holds and the input register holds
// one further event; the input channel then deasserts ready until space frees.
`default_nettype none
module single_wire_humidity_sensor_reader (
   input  wire logic                             clock,
   input  wire logic                             reset,
   swhr_req_if.sink                              req_ch,
   swhr_rsp_if.source                            rsp_ch,
   input  wire logic                             csr_wr_en,
   input  wire logic [swhr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [swhr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import swhr_pkg::*;

   cfg_type   cfg;
   logic      in_valid_ff;
   event_type in_evt_ff;
   logic      evt_take;

   // The input register refills whenever it is empty or its event moves on this cycle.
   assign req_ch.ready = !in_valid_ff || evt_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_evt_ff.mode             <= req_ch.mode;
         in_evt_ff.edge_line        <= req_ch.edge_line;
         in_evt_ff.edge_interval_us <= req_ch.edge_interval_us;
      end
   end

   swhr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The core applies the event to the protocol state and loads the result register.
   swhr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .evt_valid (in_valid_ff),
      .evt       (in_evt_ff),
      .evt_take  (evt_take),
      .rsp       (rsp_ch)
   );

`ifndef SYNTHESIS
   // A buffered event that cannot move on must stay buffered.
   a_in_held : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !evt_take) |=> in_valid_ff)
      else $error("buffered event lost");

   // A start event always yields a start-low result in the following cycle.
   a_start_result : assert property (@(posedge clock) disable iff (reset)
      (evt_take && in_evt_ff.mode == MODE_START) |=>
      (rsp_ch.valid && rsp_ch.phase == PH_START && rsp_ch.drive_low))
      else $error("start event did not reach start-low phase");

   // The ready flag reflects the ready phase exactly.
   a_ready_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.data_ready == (rsp_ch.phase == PH_READY)))
      else $error("data_ready disagrees with phase");

   // A moved event always leaves a result waiting on the output side.
   a_take_fills : assert property (@(posedge clock) disable iff (reset)
      evt_take |=> rsp_ch.valid)
      else $error("processed event produced no result");
`endif
endmodule
`default_nettype wire
